>>> src/tfpq_pkg.sv
package tfpq_pkg;

  localparam int COORD_W   = 12;
  localparam int COUNT_W   = 16;
  localparam int PIXEL_X_W = 10;
  localparam int PIXEL_Y_W = 8;

  localparam int PANEL_W_DEFAULT = 180;
  localparam int PANEL_H_DEFAULT = 640;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PRESS       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION        = 2'd2;

  localparam logic [COUNT_W-1:0] RELEASE_TIMEOUT_RESET = 16'd120;
  localparam logic [COUNT_W-1:0] MIN_PRESS_RESET       = 16'd60;
  localparam logic [COUNT_W-1:0] COUNT_MAX             = 16'hFFFF;

  localparam logic [7:0] MAX_FINGERS = 8'd2;
  localparam logic [0:0] MODE_TICK   = 1'b0;

  typedef struct packed {
    logic       mode;
    logic [7:0] finger_count;
    logic [7:0] event_y_high;
    logic [7:0] y_low;
    logic [7:0] id_x_high;
    logic [7:0] x_low;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] idle_limit;
    logic [COUNT_W-1:0] min_hold;
    logic               rotation_select;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_X_W-1:0] pixel_x;
    logic [PIXEL_Y_W-1:0] pixel_y;
    logic                 touch_pressed;
  } result_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

>>> src/tfpq_cfg.sv
module tfpq_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tfpq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tfpq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tfpq_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_limit      <= tfpq_pkg::RELEASE_TIMEOUT_RESET;
      cfg.min_hold        <= tfpq_pkg::MIN_PRESS_RESET;
      cfg.rotation_select <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tfpq_pkg::REG_RELEASE_TIMEOUT: cfg.idle_limit      <= cfg_data;
        tfpq_pkg::REG_MIN_PRESS:       cfg.min_hold        <= cfg_data;
        tfpq_pkg::REG_ROTATION:        cfg.rotation_select <= cfg_data[0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

endmodule

>>> src/tfpq_core.sv
module tfpq_core #(
  parameter int PANEL_W = tfpq_pkg::PANEL_W_DEFAULT,
  parameter int PANEL_H = tfpq_pkg::PANEL_H_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  tfpq_pkg::item_t   item,
  input  tfpq_pkg::cfg_t    cfg,
  output tfpq_pkg::result_t result
);

  localparam int CW = tfpq_pkg::COORD_W;
  localparam int NW = tfpq_pkg::COUNT_W;
  localparam logic [CW-1:0] PW = PANEL_W[CW-1:0];
  localparam logic [CW-1:0] PH = PANEL_H[CW-1:0];

  logic                               press_flag, press_flag_next;
  logic                               release_wait, release_wait_next;
  logic [tfpq_pkg::PIXEL_X_W-1:0]     hold_x, hold_x_next;
  logic [tfpq_pkg::PIXEL_Y_W-1:0]     hold_y, hold_y_next;
  logic [NW-1:0]                      ms_since_valid, ms_since_valid_next;
  logic [NW-1:0]                      ms_since_press, ms_since_press_next;

  logic [CW-1:0] raw_x, raw_y, py, lx, ly;
  logic          in_range;

  assign raw_y    = {item.event_y_high[3:0], item.y_low};
  assign raw_x    = {item.id_x_high[3:0], item.x_low};
  assign in_range = (raw_x < PW) && (raw_y < PH);
  // swap X and Y into landscape; rotation_select also mirrors both axes
  assign py = PH - CW'(1) - raw_y;
  assign lx = cfg.rotation_select ? py : raw_y;
  assign ly = cfg.rotation_select ? (PW - CW'(1) - raw_x) : raw_x;

  always_comb begin
    press_flag_next     = press_flag;
    release_wait_next   = release_wait;
    hold_x_next         = hold_x;
    hold_y_next         = hold_y;
    ms_since_valid_next = ms_since_valid;
    ms_since_press_next = ms_since_press;

    if (item.mode == tfpq_pkg::MODE_TICK[0]) begin
      ms_since_valid_next = tfpq_pkg::sat_inc(ms_since_valid);
      ms_since_press_next = tfpq_pkg::sat_inc(ms_since_press);
    end else if (item.finger_count == 8'd0) begin
      if (press_flag) begin
        release_wait_next = 1'b1;
      end
    end else if (item.finger_count <= tfpq_pkg::MAX_FINGERS && in_range) begin
      hold_x_next = lx[tfpq_pkg::PIXEL_X_W-1:0];
      hold_y_next = ly[tfpq_pkg::PIXEL_Y_W-1:0];
      if (!press_flag) begin
        ms_since_press_next = '0;
      end
      press_flag_next     = 1'b1;
      release_wait_next   = 1'b0;
      ms_since_valid_next = '0;
    end

    // release on pending release or timeout, once the minimum hold is met
    if (press_flag_next &&
        (release_wait_next || ms_since_valid_next >= cfg.idle_limit) &&
        ms_since_press_next >= cfg.min_hold) begin
      press_flag_next   = 1'b0;
      release_wait_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_flag     <= 1'b0;
      release_wait   <= 1'b0;
      hold_x         <= '0;
      hold_y         <= '0;
      ms_since_valid <= '0;
      ms_since_press <= '0;
    end else if (advance) begin
      press_flag     <= press_flag_next;
      release_wait   <= release_wait_next;
      hold_x         <= hold_x_next;
      hold_y         <= hold_y_next;
      ms_since_valid <= ms_since_valid_next;
      ms_since_press <= ms_since_press_next;
    end
  end

  assign result.pixel_x       = hold_x_next;
  assign result.pixel_y       = hold_y_next;
  assign result.touch_pressed = press_flag_next;

endmodule

>>> src/touch_frame_press_qualifier.sv
// Touch press qualifier: turns a stream of millisecond ticks and touch
// controller report frames into a clean landscape coordinate and press flag.
//
// Channels:
//   s_*   input beats. tuser is the mode (0 = 1 ms tick, 1 = report frame);
//         tdata carries the frame bytes, ignored on a tick.
//   m_*   one result beat per input beat: pixel_x, pixel_y, touch_pressed.
//   cfg_* register writes: 0 release timeout, 1 minimum press time,
//         2 rotation_select; other indexes are dropped. Always ready.
//
// An accepted input beat passes through the input register, then the press
// logic feeding the result register, where its result beat is valid.
// Throughput is one beat per cycle; both stages advance together
// whenever the result register is empty or being taken.
// When the receiver stalls, the result register holds and the input register
// holds one more beat, after which s_tready drops.
// Reset (rst, synchronous) empties both stages, clears the press state and
// loads the register defaults (timeout 120 ms, minimum press 60 ms, rotation 0).
module touch_frame_press_qualifier #(
  parameter int PANEL_W = tfpq_pkg::PANEL_W_DEFAULT,
  parameter int PANEL_H = tfpq_pkg::PANEL_H_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [7:0] finger_count, [15:8] event_y_high, [23:16] y_low,
  // [31:24] id_x_high, [39:32] x_low
  input  logic [tfpq_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [0] mode
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [9:0] pixel_x, [17:10] pixel_y, [18] touch_pressed, [23:19] zero
  output logic [tfpq_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tfpq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tfpq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tfpq_pkg::cfg_t    cfg;
  tfpq_pkg::item_t   item;
  tfpq_pkg::result_t result, result_q;
  logic              item_valid;
  logic              advance;

  tfpq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // move the held item into the result register when there is room
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.mode         <= s_tuser;
      item.finger_count <= s_tdata[7:0];
      item.event_y_high <= s_tdata[15:8];
      item.y_low        <= s_tdata[23:16];
      item.id_x_high    <= s_tdata[31:24];
      item.x_low        <= s_tdata[39:32];
    end
  end

  tfpq_core #(
    .PANEL_W (PANEL_W),
    .PANEL_H (PANEL_H)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tdata = {5'd0, result_q.touch_pressed, result_q.pixel_y, result_q.pixel_x};

endmodule
